/* design/mt_seed_outputs_lcg_index_macros.svh */
// Assertion macros shared by the design files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MT_SEED_OUTPUTS_LCG_INDEX_MACROS_SVH
`define MT_SEED_OUTPUTS_LCG_INDEX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSOL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSOL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/msol_pkg.sv */
package msol_pkg;

    localparam logic [31:0] MT_INIT_MUL   = 32'd1812433253;
    localparam logic [31:0] MT_UPPER_MASK = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER_MASK = 32'h7fff_ffff;
    localparam logic [31:0] MT_MATRIX_A   = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C   = 32'hefc6_0000;
    localparam int          MT_PICK_K     = 397;
    localparam int          MT_LAST_K     = 398;

    localparam logic [31:0] LCG_MUL  = 32'h6c07_8965;
    localparam logic [31:0] LCG_INC  = 32'd1;
    localparam int          LCG_BITS = 32;

    // Carried through the initialization stages.
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x397;
        logic [31:0] x;
    } mt_carry_t;

    // Carried through the index recovery stages.
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] state;
        logic [31:0] idx;
    } lcg_carry_t;

    typedef struct packed {
        logic [31:0] seed_echo;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [31:0] lcg_index;
    } res_t;

    function automatic logic [31:0] mt_step(input logic [31:0] prev, input logic [31:0] k);
        logic [31:0] prod;
        prod = MT_INIT_MUL * (prev ^ (prev >> 30));
        return prod + k;
    endfunction

    function automatic logic [31:0] mt_temper(input logic [31:0] w0, input logic [31:0] w1,
                                              input logic [31:0] wm);
        logic [31:0] y;
        y = (w0 & MT_UPPER_MASK) | (w1 & MT_LOWER_MASK);
        y = wm ^ (y >> 1) ^ (y[0] ? MT_MATRIX_A : 32'd0);
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Multiplier (upper half) and increment (lower half) that advance the LCG
    // by the given number of steps. Only ever called with constant arguments.
    function automatic logic [63:0] lcg_jump(input logic [31:0] steps);
        logic [31:0] pm;
        logic [31:0] pi;
        logic [31:0] am;
        logic [31:0] ai;
        pm = LCG_MUL;
        pi = LCG_INC;
        am = 32'd1;
        ai = 32'd0;
        for (int b = 0; b < LCG_BITS; b++)
        begin
            if (steps[b])
            begin
                ai = ai * pm + pi;
                am = am * pm;
            end
            pi = pi * pm + pi;
            pm = pm * pm;
        end
        return {am, ai};
    endfunction

endpackage

/* design/msol_seed_if.sv */
interface msol_seed_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink (input valid, input seed_value, output ready);
endinterface

/* design/msol_result_if.sv */
interface msol_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed_echo;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] lcg_index;

    modport source (output valid, output seed_echo, output first_word, output second_word,
                    output lcg_index, input ready);
    modport sink (input valid, input seed_echo, input first_word, input second_word,
                  input lcg_index, output ready);
endinterface

/* design/msol_skid.sv */
module msol_skid
    import msol_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  res_t                 up_data,
    output logic                 pipe_ready,
    msol_result_if.source        results
);

`include "mt_seed_outputs_lcg_index_macros.svh"

    logic main_valid_reg;
    logic main_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t main_reg;
    res_t main_next;
    res_t skid_reg;
    res_t skid_next;
    logic pop;
    logic push;

    // The pipeline only stalls once the spare entry is in use, so its enable
    // comes straight from a register.
    assign pipe_ready = !skid_valid_reg;
    assign pop        = main_valid_reg && results.ready;
    assign push       = up_valid && pipe_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = up_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = up_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign results.valid       = main_valid_reg;
    assign results.seed_echo   = main_reg.seed_echo;
    assign results.first_word  = main_reg.first_word;
    assign results.second_word = main_reg.second_word;
    assign results.lcg_index   = main_reg.lcg_index;

    `MSOL_ASSERT_IMP(a_skid_implies_main, skid_valid_reg, main_valid_reg)
    `MSOL_ASSERT_NXT(a_skid_holds, skid_valid_reg && !results.ready,
                     skid_valid_reg && $stable(skid_reg))
    `MSOL_ASSERT_NXT(a_push_lands, push && !main_valid_reg, main_valid_reg && !skid_valid_reg)

endmodule

/* design/mt_seed_outputs_lcg_index.sv */
// One seed enters per cycle and one result leaves per cycle, as long as
// the pipeline is not held. The register chain includes 398 stages that
// each apply one initialization multiply, one tempering stage, and 32 stages that
// each apply one constant jump multiply of the index recovery, then the output
// register. A two-entry output buffer lets a new seed enter while a result waits;
// the whole pipeline holds only when both entries are full.
module mt_seed_outputs_lcg_index
    import msol_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    msol_seed_if.sink     seeds,
    msol_result_if.source results
);

    mt_carry_t  mt_reg [0:MT_LAST_K];
    mt_carry_t  mt_stage_next [1:MT_LAST_K];
    logic [MT_LAST_K:0] mt_valid_reg;
    lcg_carry_t lcg_reg [0:LCG_BITS];
    lcg_carry_t lcg_stage_next [0:LCG_BITS-1];
    lcg_carry_t lcg_first;
    logic [LCG_BITS:0] lcg_valid_reg;
    logic       adv;
    res_t       final_data;

    assign seeds.ready = adv;

    // Initialization recurrence, one element per stage.
    for (genvar k = 1; k <= MT_LAST_K; k++)
    begin : g_mt
        always_comb
        begin
            mt_stage_next[k]   = mt_reg[k-1];
            mt_stage_next[k].x = mt_step(mt_reg[k-1].x, 32'(k));
            if (k == 1)
            begin
                mt_stage_next[k].x1 = mt_stage_next[k].x;
            end
            if (k == 2)
            begin
                mt_stage_next[k].x2 = mt_stage_next[k].x;
            end
            if (k == MT_PICK_K)
            begin
                mt_stage_next[k].x397 = mt_stage_next[k].x;
            end
        end
    end

    always_comb
    begin
        lcg_first.seed  = mt_reg[MT_LAST_K].seed;
        lcg_first.w1    = mt_temper(mt_reg[MT_LAST_K].seed, mt_reg[MT_LAST_K].x1,
                                    mt_reg[MT_LAST_K].x397);
        lcg_first.w2    = mt_temper(mt_reg[MT_LAST_K].x1, mt_reg[MT_LAST_K].x2,
                                    mt_reg[MT_LAST_K].x);
        lcg_first.state = lcg_first.w2;
        lcg_first.idx   = '0;
    end

    // Stage i clears bit i of the running state by stepping it back 2^i steps.
    for (genvar i = 0; i < LCG_BITS; i++)
    begin : g_lcg
        localparam logic [63:0] JUMP = lcg_jump(32'd0 - (32'd1 << i));
        always_comb
        begin
            lcg_stage_next[i] = lcg_reg[i];
            if (lcg_reg[i].state[i])
            begin
                lcg_stage_next[i].state  = lcg_reg[i].state * JUMP[63:32] + JUMP[31:0];
                lcg_stage_next[i].idx[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mt_valid_reg  <= '0;
            lcg_valid_reg <= '0;
        end
        else if (adv)
        begin
            mt_valid_reg  <= {mt_valid_reg[MT_LAST_K-1:0], seeds.valid};
            lcg_valid_reg <= {lcg_valid_reg[LCG_BITS-1:0], mt_valid_reg[MT_LAST_K]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mt_reg[0].seed <= seeds.seed_value;
            mt_reg[0].x1   <= '0;
            mt_reg[0].x2   <= '0;
            mt_reg[0].x397 <= '0;
            mt_reg[0].x    <= seeds.seed_value;
            for (int k = 1; k <= MT_LAST_K; k++)
            begin
                mt_reg[k] <= mt_stage_next[k];
            end
            lcg_reg[0] <= lcg_first;
            for (int i = 0; i < LCG_BITS; i++)
            begin
                lcg_reg[i+1] <= lcg_stage_next[i];
            end
        end
    end

    assign final_data.seed_echo   = lcg_reg[LCG_BITS].seed;
    assign final_data.first_word  = lcg_reg[LCG_BITS].w1;
    assign final_data.second_word = lcg_reg[LCG_BITS].w2;
    assign final_data.lcg_index   = lcg_reg[LCG_BITS].idx;

    msol_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (lcg_valid_reg[LCG_BITS]),
        .up_data    (final_data),
        .pipe_ready (adv),
        .results    (results)
    );

endmodule
